// ===== hw/rtl/jdcal_pkg.sv =====
// Package for the Julian day to calendar date converter.
// Holds the transaction types, the fixed field widths, the algorithm constants and
// the month start tables. No dependencies.
package jdcal_pkg;

   // Input field widths
   localparam int DAY_BITS      = 23;
   localparam int FRACTION_BITS = 32;

   // Pipeline depth, including the output register
   localparam int STAGES = 10;

   // Algorithm constants as exact integer ratios
   localparam int GREGORIAN_FIRST_DAY = 2299161;
   localparam int ALPHA_OFFSET        = 7468865;   // 4 * 1867216.25
   localparam int ALPHA_DIV           = 146097;    // 4 * 36524.25
   localparam int B_OFFSET            = 1524;
   localparam int C_OFFSET            = 2442;      // 20 * 122.1
   localparam int C_MUL               = 20;
   localparam int C_DIV               = 7305;      // 20 * 365.25
   localparam int D_MUL               = 1461;      // 4 * 365.25
   localparam int YEAR_OFFSET_LATE    = 4716;
   localparam int YEAR_OFFSET_EARLY   = 4715;
   localparam int MONTH_WRAP          = 14;
   localparam int MONTH_SHIFT_LOW     = 1;
   localparam int MONTH_SHIFT_HIGH    = 13;
   localparam int FEBRUARY            = 2;
   localparam int HOURS_PER_DAY       = 24;
   localparam int SIXTY               = 60;

   // Derived widths of the date path
   localparam int X1_W = DAY_BITS + 2;           // 4 * day number
   localparam int M1_W = X1_W - 17;              // reciprocal of ALPHA_DIV (> 2^17)
   localparam int B_W  = DAY_BITS + 1;
   localparam int X2_W = B_W + 5;                // 20 * b
   localparam int M2_W = X2_W - 12;              // reciprocal of C_DIV (> 2^12)
   localparam int C_W  = M2_W;
   localparam int D_W  = C_W + 9;                // floor(1461 * c / 4)
   localparam int BD_W = 9;                      // b - d lies in 123 .. 488
   localparam int E_W  = 4;                      // e lies in 4 .. 15
   localparam int Y_W  = 16;

   // Truncated reciprocals, worked out at elaboration
   localparam longint unsigned M1 = (64'd1 << X1_W) / ALPHA_DIV;
   localparam longint unsigned M2 = (64'd1 << X2_W) / C_DIV;

   typedef struct packed {
      logic [DAY_BITS-1:0]      day_number;
      logic [FRACTION_BITS-1:0] day_fraction;
   } jdcal_req_type;

   typedef struct packed {
      logic signed [15:0] year;
      logic [3:0]         month;
      logic [4:0]         day_of_month;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         second;
   } jdcal_rsp_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } jdcal_tod_type;

   // ceil(30.6001 * k): smallest b - d that gives e >= k
   function automatic logic [BD_W-1:0] month_start_ceil(input logic [E_W-1:0] k);
      logic [BD_W-1:0] v;
      case (k)
         4'd1:    v = 9'd31;
         4'd2:    v = 9'd62;
         4'd3:    v = 9'd92;
         4'd4:    v = 9'd123;
         4'd5:    v = 9'd154;
         4'd6:    v = 9'd184;
         4'd7:    v = 9'd215;
         4'd8:    v = 9'd245;
         4'd9:    v = 9'd276;
         4'd10:   v = 9'd307;
         4'd11:   v = 9'd337;
         4'd12:   v = 9'd368;
         4'd13:   v = 9'd398;
         4'd14:   v = 9'd429;
         4'd15:   v = 9'd460;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   // floor(30.6001 * k): offset subtracted to give the day of month
   function automatic logic [BD_W-1:0] month_start_floor(input logic [E_W-1:0] k);
      logic [BD_W-1:0] v;
      case (k)
         4'd1:    v = 9'd30;
         4'd2:    v = 9'd61;
         4'd3:    v = 9'd91;
         4'd4:    v = 9'd122;
         4'd5:    v = 9'd153;
         4'd6:    v = 9'd183;
         4'd7:    v = 9'd214;
         4'd8:    v = 9'd244;
         4'd9:    v = 9'd275;
         4'd10:   v = 9'd306;
         4'd11:   v = 9'd336;
         4'd12:   v = 9'd367;
         4'd13:   v = 9'd397;
         4'd14:   v = 9'd428;
         4'd15:   v = 9'd459;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== hw/rtl/julian_day_to_calendar_date.sv =====
// Julian day number and day fraction to calendar date and time of day; uses jdcal_pkg.
// Each input transaction reaches the result through a ten-register pipeline.
// Throughput: one transaction per cycle; a stalled stage holds only itself and the
// stages before it, so bubbles are squeezed out while the output waits.
// Reset clears the stage valid bits only; the data registers are not reset.
module julian_day_to_calendar_date
   import jdcal_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  jdcal_req_type req_payload,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output jdcal_rsp_type rsp_payload
);

   // Stage valid bits and ready chain
   logic [STAGES:1] v_ff;
   logic [STAGES:1] rdy;

   // Stage 1
   logic [DAY_BITS-1:0]      s1_z_ff,    s1_z_in;
   logic                     s1_greg_ff, s1_greg_in;
   logic [X1_W-1:0]          s1_x1_ff,   s1_x1_in;
   logic [4:0]               s1_hour_ff, s1_hour_in;
   logic [FRACTION_BITS-1:0] s1_rem_ff,  s1_rem_in;
   // Stage 2
   logic [DAY_BITS-1:0]      s2_z_ff,      s2_z_in;
   logic                     s2_greg_ff,   s2_greg_in;
   logic [X1_W-1:0]          s2_x1_ff,     s2_x1_in;
   logic [X1_W+M1_W-1:0]     s2_p1_ff,     s2_p1_in;
   logic [4:0]               s2_hour_ff,   s2_hour_in;
   logic [5:0]               s2_minute_ff, s2_minute_in;
   logic [FRACTION_BITS-1:0] s2_rem_ff,    s2_rem_in;
   // Stage 3
   logic [DAY_BITS-1:0]      s3_z_ff,     s3_z_in;
   logic                     s3_greg_ff,  s3_greg_in;
   logic [M1_W-1:0]          s3_alpha_ff, s3_alpha_in;
   // Stages 4 to 9
   logic [B_W-1:0]           s4_b_ff,  s4_b_in;
   logic [B_W-1:0]           s5_b_ff,  s5_b_in;
   logic [X2_W-1:0]          s5_x2_ff, s5_x2_in;
   logic [B_W-1:0]           s6_b_ff,  s6_b_in;
   logic [X2_W-1:0]          s6_x2_ff, s6_x2_in;
   logic [X2_W+M2_W-1:0]     s6_p2_ff, s6_p2_in;
   logic [B_W-1:0]           s7_b_ff,  s7_b_in;
   logic [C_W-1:0]           s7_c_ff,  s7_c_in;
   logic [BD_W-1:0]          s8_bd_ff, s8_bd_in;
   logic [C_W-1:0]           s8_c_ff,  s8_c_in;
   logic [BD_W-1:0]          s9_bd_ff, s9_bd_in;
   logic [E_W-1:0]           s9_e_ff,  s9_e_in;
   logic [C_W-1:0]           s9_c_ff,  s9_c_in;
   // Time of day carried from stage 3 to stage 9
   jdcal_tod_type            tod_ff [3:9];
   jdcal_tod_type            tod_in [3:9];
   // Output register
   jdcal_rsp_type            rsp_ff, rsp_in;

   // Combinational temporaries
   logic [FRACTION_BITS+4:0] t1;
   logic [FRACTION_BITS+5:0] t2;
   logic [FRACTION_BITS+5:0] t3;
   logic [M1_W-1:0]          q1;
   logic [X1_W-1:0]          r1;
   logic [B_W-1:0]           a_greg;
   logic [M2_W-1:0]          q2;
   logic [X2_W-1:0]          r2;
   logic [C_W+10:0]          dprod;
   logic [D_W-1:0]           bd_full;
   logic [15:1]              ge;
   logic [3:0]               month;
   logic [C_W:0]             year_full;
   logic [BD_W-1:0]          dom_full;

   // Ready chain: a stage takes new data when empty or when its content moves on
   always_comb begin
      rdy[STAGES] = !v_ff[STAGES] || rsp_ready;
      for (int i = STAGES - 1; i >= 1; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   assign req_ready   = rdy[1];
   assign rsp_valid   = v_ff[STAGES];
   assign rsp_payload = rsp_ff;

   // Stage 1: calendar select, alpha numerator, hour
   always_comb begin
      s1_z_in    = req_payload.day_number;
      s1_greg_in = (req_payload.day_number >= DAY_BITS'(GREGORIAN_FIRST_DAY));
      s1_x1_in   = s1_greg_in ? ({req_payload.day_number, 2'b00} - X1_W'(ALPHA_OFFSET))
                              : '0;
      t1         = (FRACTION_BITS+5)'(req_payload.day_fraction)
                   * (FRACTION_BITS+5)'(HOURS_PER_DAY);
      s1_hour_in = t1[FRACTION_BITS+4:FRACTION_BITS];
      s1_rem_in  = t1[FRACTION_BITS-1:0];
   end

   // Stage 2: reciprocal product for alpha, minute
   always_comb begin
      s2_z_in      = s1_z_ff;
      s2_greg_in   = s1_greg_ff;
      s2_x1_in     = s1_x1_ff;
      s2_p1_in     = (X1_W+M1_W)'(s1_x1_ff) * (X1_W+M1_W)'(M1);
      s2_hour_in   = s1_hour_ff;
      t2           = (FRACTION_BITS+6)'(s1_rem_ff) * (FRACTION_BITS+6)'(SIXTY);
      s2_minute_in = t2[FRACTION_BITS+5:FRACTION_BITS];
      s2_rem_in    = t2[FRACTION_BITS-1:0];
   end

   // Stage 3: correct the alpha quotient, second; carry the time of day onwards
   always_comb begin
      q1          = s2_p1_ff[X1_W+M1_W-1:X1_W];
      r1          = s2_x1_ff - X1_W'(q1) * X1_W'(ALPHA_DIV);
      s3_alpha_in = q1 + M1_W'(r1 >= X1_W'(ALPHA_DIV));
      s3_z_in     = s2_z_ff;
      s3_greg_in  = s2_greg_ff;
      t3          = (FRACTION_BITS+6)'(s2_rem_ff) * (FRACTION_BITS+6)'(SIXTY);
      tod_in[3].hour   = s2_hour_ff;
      tod_in[3].minute = s2_minute_ff;
      tod_in[3].second = t3[FRACTION_BITS+5:FRACTION_BITS];
      for (int i = 4; i <= 9; i++) begin
         tod_in[i] = tod_ff[i-1];
      end
   end

   // Stage 4: apply the Gregorian correction, form b
   always_comb begin
      a_greg  = B_W'(s3_z_ff) + B_W'(1) + B_W'(s3_alpha_ff) - B_W'(s3_alpha_ff >> 2);
      s4_b_in = (s3_greg_ff ? a_greg : B_W'(s3_z_ff)) + B_W'(B_OFFSET);
   end

   // Stage 5: numerator of c
   always_comb begin
      s5_b_in  = s4_b_ff;
      s5_x2_in = X2_W'(s4_b_ff) * X2_W'(C_MUL) - X2_W'(C_OFFSET);
   end

   // Stage 6: reciprocal product for c
   always_comb begin
      s6_b_in  = s5_b_ff;
      s6_x2_in = s5_x2_ff;
      s6_p2_in = (X2_W+M2_W)'(s5_x2_ff) * (X2_W+M2_W)'(M2);
   end

   // Stage 7: correct the c quotient
   always_comb begin
      q2      = s6_p2_ff[X2_W+M2_W-1:X2_W];
      r2      = s6_x2_ff - X2_W'(q2) * X2_W'(C_DIV);
      s7_c_in = q2 + C_W'(r2 >= X2_W'(C_DIV));
      s7_b_in = s6_b_ff;
   end

   // Stage 8: d and the day count within the March-based year
   always_comb begin
      dprod    = (C_W+11)'(s7_c_ff) * (C_W+11)'(D_MUL);
      bd_full  = D_W'(s7_b_ff) - dprod[C_W+10:2];
      s8_bd_in = bd_full[BD_W-1:0];
      s8_c_in  = s7_c_ff;
   end

   // Stage 9: e by comparing against the month start thresholds
   always_comb begin
      for (int k = 1; k <= 15; k++) begin
         ge[k] = (s8_bd_ff >= month_start_ceil(E_W'(k)));
      end
      s9_e_in  = E_W'($countones(ge));
      s9_bd_in = s8_bd_ff;
      s9_c_in  = s8_c_ff;
   end

   // Stage 10: day of month, month and year into the output register
   always_comb begin
      dom_full  = s9_bd_ff - month_start_floor(s9_e_ff);
      month     = (s9_e_ff < E_W'(MONTH_WRAP)) ? (s9_e_ff - 4'(MONTH_SHIFT_LOW))
                                               : (s9_e_ff - 4'(MONTH_SHIFT_HIGH));
      year_full = (month > 4'(FEBRUARY)) ? ({1'b0, s9_c_ff} - (C_W+1)'(YEAR_OFFSET_LATE))
                                         : ({1'b0, s9_c_ff} - (C_W+1)'(YEAR_OFFSET_EARLY));
      rsp_in.year         = year_full[Y_W-1:0];
      rsp_in.month        = month;
      rsp_in.day_of_month = dom_full[4:0];
      rsp_in.hour         = tod_ff[9].hour;
      rsp_in.minute       = tod_ff[9].minute;
      rsp_in.second       = tod_ff[9].second;
   end

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[1]) begin
            v_ff[1] <= req_valid;
         end
         for (int i = 2; i <= STAGES; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // Advance the data registers; hold a stage while it is stalled
   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_z_ff    <= s1_z_in;
         s1_greg_ff <= s1_greg_in;
         s1_x1_ff   <= s1_x1_in;
         s1_hour_ff <= s1_hour_in;
         s1_rem_ff  <= s1_rem_in;
      end
      if (rdy[2]) begin
         s2_z_ff      <= s2_z_in;
         s2_greg_ff   <= s2_greg_in;
         s2_x1_ff     <= s2_x1_in;
         s2_p1_ff     <= s2_p1_in;
         s2_hour_ff   <= s2_hour_in;
         s2_minute_ff <= s2_minute_in;
         s2_rem_ff    <= s2_rem_in;
      end
      if (rdy[3]) begin
         s3_z_ff     <= s3_z_in;
         s3_greg_ff  <= s3_greg_in;
         s3_alpha_ff <= s3_alpha_in;
      end
      if (rdy[4]) begin
         s4_b_ff <= s4_b_in;
      end
      if (rdy[5]) begin
         s5_b_ff  <= s5_b_in;
         s5_x2_ff <= s5_x2_in;
      end
      if (rdy[6]) begin
         s6_b_ff  <= s6_b_in;
         s6_x2_ff <= s6_x2_in;
         s6_p2_ff <= s6_p2_in;
      end
      if (rdy[7]) begin
         s7_b_ff <= s7_b_in;
         s7_c_ff <= s7_c_in;
      end
      if (rdy[8]) begin
         s8_bd_ff <= s8_bd_in;
         s8_c_ff  <= s8_c_in;
      end
      if (rdy[9]) begin
         s9_bd_ff <= s9_bd_in;
         s9_e_ff  <= s9_e_in;
         s9_c_ff  <= s9_c_in;
      end
      for (int i = 3; i <= 9; i++) begin
         if (rdy[i]) begin
            tod_ff[i] <= tod_in[i];
         end
      end
      if (rdy[STAGES]) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTH
   // An accepted transaction lands in the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v_ff[1])
      else $error("accepted transaction did not enter stage 1");

   // A stalled middle stage keeps its transaction and its data
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (v_ff[5] && !rdy[5]) |=> (v_ff[5] && $stable(s5_x2_ff)))
      else $error("stalled stage 5 lost or changed its transaction");

   // The month index always falls in March to February of the next year
   a_e_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[9] |-> (s9_e_ff >= 4'd4))
      else $error("month index e out of range");

   // Every result has a month in 1 to 12 and a day of month of at least 1
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.month >= 4'd1 && rsp_payload.month <= 4'd12 &&
                     rsp_payload.day_of_month >= 5'd1))
      else $error("result month or day of month out of range");
`endif

endmodule
